@@ sv/ikc_pkg.sv @@
package ikc_pkg;

  localparam int DIV_DW = 23;
  localparam int DIV_VW = 12;
  localparam int CNT_W  = 13;
  localparam int POS_W  = 23;

  typedef enum logic [2:0] {
    MASK_BOX3    = 3'd0,
    MASK_GAUSS3  = 3'd1,
    MASK_GAUSS5  = 3'd2,
    MASK_SOBEL_V = 3'd3,
    MASK_SOBEL_H = 3'd4
  } mask_t;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_MASK    = 2'd2,
    REG_DIVISOR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic take;
    logic shift;
    logic pos_start;
    logic pos_latch;
    logic mac_step;
    logic sum_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic needs_shift;
    logic emit;
    logic border;
    logic div_done;
    logic mac_last;
    logic out_free;
  } status_t;

  localparam logic signed [6:0] K_BOX3 [9] = '{7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1,
                                               7'sd1, 7'sd1, 7'sd1, 7'sd1};
  localparam logic signed [6:0] K_GAUSS3 [9] = '{7'sd1, 7'sd2, 7'sd1, 7'sd2, 7'sd4,
                                                 7'sd2, 7'sd1, 7'sd2, 7'sd1};
  localparam logic signed [6:0] K_SOBEL_V [9] = '{7'sd1, 7'sd2, 7'sd1, 7'sd0, 7'sd0,
                                                  7'sd0, -7'sd1, -7'sd2, -7'sd1};
  localparam logic signed [6:0] K_SOBEL_H [9] = '{7'sd1, 7'sd0, -7'sd1, 7'sd2, 7'sd0,
                                                  -7'sd2, 7'sd1, 7'sd0, -7'sd1};
  localparam logic signed [6:0] K_GAUSS5 [25] = '{
    7'sd1, 7'sd4, 7'sd6, 7'sd4, 7'sd1,
    7'sd4, 7'sd16, 7'sd24, 7'sd16, 7'sd4,
    7'sd6, 7'sd24, 7'sd36, 7'sd24, 7'sd6,
    7'sd4, 7'sd16, 7'sd24, 7'sd16, 7'sd4,
    7'sd1, 7'sd4, 7'sd6, 7'sd4, 7'sd1};

  function automatic logic signed [6:0] coef(logic [2:0] m, logic [2:0] i, logic [2:0] j);
    logic [4:0] k5;
    logic [3:0] k3;
    logic       in3;
    logic signed [6:0] c;
    k5  = 5'(i * 3'd5 + j);
    in3 = (i >= 3'd2) && (j >= 3'd2);
    k3  = in3 ? 4'((i - 3'd2) * 3'd3 + (j - 3'd2)) : 4'd0;
    case (m)
      MASK_GAUSS5:  c = K_GAUSS5[k5];
      MASK_GAUSS3:  c = in3 ? K_GAUSS3[k3] : 7'sd0;
      MASK_SOBEL_V: c = in3 ? K_SOBEL_V[k3] : 7'sd0;
      MASK_SOBEL_H: c = in3 ? K_SOBEL_H[k3] : 7'sd0;
      default:      c = in3 ? K_BOX3[k3] : 7'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/image_kernel_convolution.sv @@
// Streaming 3x3/5x5 convolution over 8-bit raster pixels with a four-row line
// buffer, one beat at a time. A beat that yields no result takes the pixel and
// shifts the window; one with a border result also runs the position divide;
// one with an interior result then adds a multiply-accumulate over all 25
// window taps and a sum divide. The single restoring divider is shared by both
// divides, the MAC adds one tap per step, and a stalled result holds off the
// next beat. A flush beat drains one pending output; the last one of a frame
// carries frame_last. The line buffer is not cleared after reset.
module image_kernel_convolution
  import ikc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [7:0]         pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] value,
  output logic               is_border,
  output logic               frame_last,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  cmd_t    cmd;
  status_t sts;

  ikc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ikc_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (op),
    .pixel      (pixel),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .is_border  (is_border),
    .frame_last (frame_last)
  );

endmodule

@@ sv/ikc_div.sv @@
module ikc_div
  import ikc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_DW-1:0] dividend,
  input  logic [DIV_VW-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIV_DW-1:0] quotient,
  output logic [DIV_VW-1:0] remainder
);

  localparam int CW = $clog2(DIV_DW + 1);

  logic [CW-1:0]     cnt;
  logic [DIV_VW-1:0] dvs;
  logic [DIV_VW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {remainder, quotient[DIV_DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      cnt       <= '0;
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (fits) begin
        remainder <= DIV_VW'(rem_sh - {1'b0, dvs});
      end else begin
        remainder <= rem_sh[DIV_VW-1:0];
      end
      quotient <= {quotient[DIV_DW-2:0], fits};
      cnt      <= cnt + 1'b1;
      done     <= cnt == CW'(DIV_DW - 1);
      if (cnt == CW'(DIV_DW - 1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

@@ sv/ikc_ctrl.sv @@
module ikc_ctrl
  import ikc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_POS, S_CHECK, S_MAC, S_SUM, S_SUMWAIT, S_OUT
  } state_t;

  state_t state;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.take      = state == S_IDLE && in_valid;
    cmd.shift     = state == S_SHIFT && sts.needs_shift;
    cmd.pos_start = cmd.shift && sts.emit;
    cmd.pos_latch = state == S_POS && sts.div_done;
    cmd.mac_step  = state == S_MAC;
    cmd.sum_start = state == S_SUM;
    cmd.load_out  = state == S_OUT && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:    if (in_valid) state <= S_SHIFT;
        S_SHIFT:   state <= (sts.needs_shift && sts.emit) ? S_POS : S_IDLE;
        S_POS:     if (sts.div_done) state <= S_CHECK;
        S_CHECK:   state <= sts.border ? S_OUT : S_MAC;
        S_MAC:     if (sts.mac_last) state <= S_SUM;
        S_SUM:     state <= S_SUMWAIT;
        S_SUMWAIT: if (sts.div_done) state <= S_OUT;
        S_OUT:     if (sts.out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/ikc_datapath.sv @@
module ikc_datapath
  import ikc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic               op,
  input  logic [7:0]         pixel,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] value,
  output logic               is_border,
  output logic               frame_last
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int CMPW   = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int EW_MAX = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;

  logic [10:0] image_width;
  logic [11:0] image_height;
  logic [2:0]  mask_select;
  logic [11:0] divisor;

  logic [10:0]      ew;
  logic [11:0]      ew_p1;
  logic [11:0]      eh;
  logic [1:0]       rad;
  logic [POS_W-1:0] wh;
  logic [12:0]      lag;
  logic [11:0]      dvs_eff;

  logic       op_q;
  logic [7:0] pix_q;

  logic [31:0] line_mem [MAX_WIDTH];
  logic [31:0] rd_word;
  logic [31:0] new_word;
  logic [7:0]  col [5];
  logic [7:0]  win [5][5];

  logic [AW-1:0]    in_column;
  logic [11:0]      in_row;
  logic [POS_W-1:0] out_position;
  logic [CNT_W-1:0] shifted_cnt;
  logic [CNT_W-1:0] pending_cnt;
  logic             fl_q;

  logic [AW-1:0]    in_column_next;
  logic [11:0]      in_row_next;
  logic [POS_W-1:0] out_position_next;
  logic [CNT_W-1:0] shifted_next;
  logic [CNT_W-1:0] pending_next;
  logic             last;
  logic [POS_W:0]   pos_inc;
  logic [CMPW-1:0]  col_inc;

  logic              div_start;
  logic              div_busy;
  logic [DIV_DW-1:0] div_dividend;
  logic [DIV_VW-1:0] div_divisor;
  logic [DIV_DW-1:0] div_q;
  logic [DIV_VW-1:0] div_r;

  logic              border_c;
  logic              border_q;
  logic [2:0]        ti;
  logic [2:0]        tj;
  logic signed [17:0] acc;
  logic [16:0]       acc_mag;
  logic [16:0]       q17;

  always_comb begin
    if (image_width < 11'd5) begin
      ew = 11'd5;
    end else if ({21'b0, image_width} > MAX_WIDTH) begin
      ew = 11'(MAX_WIDTH);
    end else begin
      ew = image_width;
    end
  end

  assign eh      = (image_height < 12'd5) ? 12'd5 : image_height;
  assign rad     = (mask_select == MASK_GAUSS5) ? 2'd2 : 2'd1;
  assign wh      = POS_W'(ew * eh);
  assign ew_p1   = {1'b0, ew} + 12'd1;
  assign lag     = (rad == 2'd2) ? {ew_p1, 1'b0} : {1'b0, ew_p1};
  assign dvs_eff = (divisor == 12'd0) ? 12'd1 : divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd64;
      image_height <= 12'd64;
      mask_select  <= 3'd0;
      divisor      <= 12'd1;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:   image_width  <= cfg_data[10:0];
        REG_HEIGHT:  image_height <= cfg_data;
        REG_MASK:    mask_select  <= cfg_data[2:0];
        REG_DIVISOR: divisor      <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q    <= op;
      pix_q   <= pixel;
      rd_word <= line_mem[in_column];
    end
    if (cmd.shift) begin
      line_mem[in_column] <= new_word;
    end
  end

  always_comb begin
    col[0]   = rd_word[31:24];
    col[1]   = rd_word[23:16];
    col[2]   = rd_word[15:8];
    col[3]   = rd_word[7:0];
    col[4]   = op_q ? 8'd0 : pix_q;
    new_word = {col[1], col[2], col[3], col[4]};
  end

  assign sts.needs_shift = !op_q || pending_cnt != '0;
  assign sts.emit        = {1'b0, shifted_cnt} + 14'd1 > {1'b0, lag};
  assign last            = op_q && pending_cnt == CNT_W'(1) && sts.emit;
  assign col_inc         = CMPW'(in_column) + CMPW'(1);
  assign pos_inc         = {1'b0, out_position} + 1'b1;

  always_comb begin
    in_column_next = AW'(col_inc);
    in_row_next    = in_row;
    if (col_inc >= CMPW'(ew)) begin
      in_column_next = '0;
      in_row_next    = (in_row + 12'd1 >= eh) ? 12'd0 : in_row + 12'd1;
    end
    shifted_next      = shifted_cnt + 1'b1;
    pending_next      = op_q ? pending_cnt : pending_cnt + 1'b1;
    out_position_next = out_position;
    if (sts.emit) begin
      shifted_next      = shifted_cnt;
      pending_next      = op_q ? pending_cnt - 1'b1 : pending_cnt;
      out_position_next = (pos_inc >= {1'b0, wh}) ? '0 : pos_inc[POS_W-1:0];
    end
    if (last) begin
      in_column_next    = '0;
      in_row_next       = '0;
      out_position_next = '0;
      shifted_next      = '0;
      pending_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 5; r++) begin
        for (int k = 0; k < 5; k++) begin
          win[r][k] <= 8'd0;
        end
      end
      in_column    <= '0;
      in_row       <= '0;
      out_position <= '0;
      shifted_cnt  <= '0;
      pending_cnt  <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 5; r++) begin
        for (int k = 0; k < 4; k++) begin
          win[r][k] <= win[r][k+1];
        end
        win[r][4] <= col[r];
      end
      in_column    <= in_column_next;
      in_row       <= in_row_next;
      out_position <= out_position_next;
      shifted_cnt  <= shifted_next;
      pending_cnt  <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      fl_q <= last || pos_inc >= {1'b0, wh};
    end
  end

  assign div_start    = cmd.pos_start || cmd.sum_start;
  assign div_dividend = cmd.pos_start ? out_position : DIV_DW'(acc_mag);
  assign div_divisor  = cmd.pos_start ? {1'b0, ew} : dvs_eff;

  ikc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (sts.div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign border_c = div_q < DIV_DW'(rad)
                 || {1'b0, div_q} + (DIV_DW + 1)'(rad) >= (DIV_DW + 1)'(eh)
                 || div_r < DIV_VW'(rad)
                 || {1'b0, div_r} + (DIV_VW + 1)'(rad) >= (DIV_VW + 1)'(ew);

  assign acc_mag = acc[17] ? 17'(-acc) : acc[16:0];
  assign q17     = div_q[16:0];

  always_ff @(posedge clk) begin
    if (cmd.pos_latch) begin
      border_q <= border_c;
      acc      <= '0;
      ti       <= 3'd0;
      tj       <= 3'd0;
    end else if (cmd.mac_step) begin
      acc <= acc + 18'(signed'({1'b0, win[ti][tj]}) * coef(mask_select, ti, tj));
      if (tj == 3'd4) begin
        tj <= 3'd0;
        ti <= ti + 3'd1;
      end else begin
        tj <= tj + 3'd1;
      end
    end
  end

  assign sts.border   = border_q;
  assign sts.mac_last = ti == 3'd4 && tj == 3'd4;
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (border_q) begin
        value <= {9'd0, (rad == 2'd2) ? win[2][2] : win[3][3]};
      end else begin
        value <= acc[17] ? -signed'(q17) : signed'(q17);
      end
      is_border  <= border_q;
      frame_last <= fl_q;
    end
  end

  a_pending_le_shifted: assert property (@(posedge clk) disable iff (rst)
    pending_cnt <= shifted_cnt)
    else $error("pending count above shifted count");

  a_shifted_bound: assert property (@(posedge clk) disable iff (rst)
    shifted_cnt <= CNT_W'(2 * EW_MAX + 2))
    else $error("shifted count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_out && out_valid && out_stall))
    else $error("result loaded over a stalled beat");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
